[design/stack_bytecode_executor_defines.svh]
// Assertion macros for the stack bytecode executor.
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SBE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SBE_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SBE_ASSERT(label, prop, msg)
`define SBE_ASSERT_RST(label, prop, msg)
`endif

`endif

[design/sbe_pkg.sv]
package sbe_pkg;

  localparam int SBE_STACK_DEPTH = 64;
  localparam int SBE_PC_BITS     = 16;
  localparam int SBE_WORD_W      = 32;
  localparam int SBE_LIMIT_W     = 7;
  localparam int SBE_NPC_W       = 16;

  typedef logic [SBE_WORD_W-1:0] word_t;

  localparam logic [SBE_LIMIT_W-1:0] SBE_LIMIT_RST = 7'd64;
  localparam word_t SBE_NEG_ONE = '1;

  typedef enum logic [3:0] {
    OP_RET   = 4'd0,
    OP_PUSH  = 4'd1,
    OP_CALL  = 4'd2,
    OP_ADD   = 4'd3,
    OP_SUB   = 4'd4,
    OP_MUL   = 4'd5,
    OP_DIV   = 4'd6,
    OP_GOTO  = 4'd7,
    OP_BRZ   = 4'd8,
    OP_CMP   = 4'd9,
    OP_DUP   = 4'd10,
    OP_DEBUG = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OVER      = 3'd1,
    ST_UNDER     = 3'd2,
    ST_DIVZ      = 3'd3,
    ST_NOTSINGLE = 3'd4,
    ST_BADOP     = 3'd5
  } status_t;

  typedef struct packed {
    logic  start;
    word_t dividend;
    word_t divisor;
  } div_req_t;

  typedef struct packed {
    logic  done;
    word_t quotient;
  } div_rsp_t;

endpackage

[design/sbe_stack_mem.sv]
module sbe_stack_mem import sbe_pkg::*; #(
  parameter int DEPTH = SBE_STACK_DEPTH,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              en,
  input  logic              we,
  input  logic [ADDR_W-1:0] addr,
  input  word_t             wdata,
  output word_t             rdata
);

  word_t mem_r [DEPTH];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem_r[addr] <= wdata;
      end else begin
        rdata_r <= mem_r[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

[design/sbe_div.sv]
module sbe_div import sbe_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CNT_W = $clog2(SBE_WORD_W);

  word_t             rem_r;
  word_t             quo_r;
  word_t             dvs_r;
  logic              neg_r;
  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [SBE_WORD_W:0] rem_sh;
  logic [SBE_WORD_W:0] diff;
  logic              rem_ge;
  word_t             mag_a;
  word_t             mag_b;

  always_comb begin
    rem_sh = {rem_r, quo_r[SBE_WORD_W-1]};
    diff   = rem_sh - {1'b0, dvs_r};
    rem_ge = !diff[SBE_WORD_W];
    mag_a  = req.dividend[SBE_WORD_W-1] ? (word_t'(0) - req.dividend) : req.dividend;
    mag_b  = req.divisor[SBE_WORD_W-1] ? (word_t'(0) - req.divisor) : req.divisor;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (req.start) begin
      rem_r  <= '0;
      quo_r  <= mag_a;
      dvs_r  <= mag_b;
      neg_r  <= req.dividend[SBE_WORD_W-1] ^ req.divisor[SBE_WORD_W-1];
      cnt_r  <= '0;
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r) begin
      rem_r <= rem_ge ? diff[SBE_WORD_W-1:0] : rem_sh[SBE_WORD_W-1:0];
      quo_r <= {quo_r[SBE_WORD_W-2:0], rem_ge};
      cnt_r <= cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(SBE_WORD_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? (word_t'(0) - quo_r) : quo_r;

endmodule

[design/stack_bytecode_executor.sv]
// Stack bytecode executor: runs one stack-machine instruction per input transfer and returns
// one result transfer with the next pc and a status. The top of stack sits in a register and
// the entries below it in a single-port synchronous memory, so each cycle needs at most
// one memory access: the entry under the top is read in the accept cycle and the instruction
// completes in the S_EXEC state that follows. Divide runs through a one-bit-per-cycle divider.
// Completion waits while the output register holds an untaken result. stack_limit is written
// through cfg_wr_en/cfg_wr_data, by the user only while the block is idle; it does not check.
`include "stack_bytecode_executor_defines.svh"

module stack_bytecode_executor import sbe_pkg::*; #(
  parameter int STACK_DEPTH = SBE_STACK_DEPTH,
  parameter int PC_BITS     = SBE_PC_BITS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [SBE_LIMIT_W-1:0] cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [3:0]             in_mode,
  input  logic signed [31:0]     in_operand,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [SBE_NPC_W-1:0]   out_next_pc,
  output logic                   out_done_res,
  output logic signed [31:0]     out_return_value,
  output logic [2:0]             out_status
);

  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam int DEP_W  = $clog2(STACK_DEPTH + 1);
  localparam int LIM_W  = (DEP_W > SBE_LIMIT_W) ? DEP_W : SBE_LIMIT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DIV
  } state_t;

  state_t                 state_r, state_nxt;
  logic [DEP_W-1:0]       depth_r, depth_nxt;
  logic [PC_BITS-1:0]     pc_r, pc_nxt;
  word_t                  tos_r, tos_nxt;
  logic [SBE_LIMIT_W-1:0] limit_r;
  logic [3:0]             mode_r;
  word_t                  opnd_r;

  logic                   out_valid_r, out_valid_nxt;
  logic [SBE_NPC_W-1:0]   out_npc_r, out_npc_nxt;
  logic                   out_done_r, out_done_nxt;
  word_t                  out_rv_r, out_rv_nxt;
  status_t                out_st_r, out_st_nxt;

  logic                   mem_en;
  logic                   mem_we;
  logic [ADDR_W-1:0]      mem_addr;
  word_t                  mem_rdata;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  logic [DEP_W-1:0]       dep_m1;
  logic [DEP_W-1:0]       dep_m2;
  logic                   full;
  logic                   out_free;
  logic [PC_BITS-1:0]     pc_inc1;
  logic [PC_BITS-1:0]     pc_inc2;
  logic [PC_BITS-1:0]     target;
  word_t                  alu;
  logic [31:0]            npc_ext;

  logic                   res_commit;
  logic [PC_BITS-1:0]     res_npc;
  logic                   res_done;
  word_t                  res_rv;
  status_t                res_st;

  sbe_stack_mem #(
    .DEPTH (STACK_DEPTH)
  ) u_mem (
    .clk   (clk),
    .en    (mem_en),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (tos_r),
    .rdata (mem_rdata)
  );

  sbe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign dep_m1   = depth_r - DEP_W'(1);
  assign dep_m2   = depth_r - DEP_W'(2);
  assign full     = (LIM_W'(depth_r) >= LIM_W'(limit_r)) || (depth_r == DEP_W'(STACK_DEPTH));
  assign out_free = !out_valid_r || out_ready;
  assign pc_inc1  = pc_r + PC_BITS'(1);
  assign pc_inc2  = pc_r + PC_BITS'(2);
  assign target   = opnd_r[PC_BITS-1:0];

  // mem_rdata holds the entry under the top, tos_r the top
  always_comb begin
    unique case (mode_r)
      OP_ADD:  alu = mem_rdata + tos_r;
      OP_SUB:  alu = mem_rdata - tos_r;
      OP_MUL:  alu = mem_rdata * tos_r;
      default: begin
        if ($signed(mem_rdata) < $signed(tos_r)) begin
          alu = SBE_NEG_ONE;
        end else if ($signed(mem_rdata) > $signed(tos_r)) begin
          alu = word_t'(1);
        end else begin
          alu = '0;
        end
      end
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    depth_nxt     = depth_r;
    pc_nxt        = pc_r;
    tos_nxt       = tos_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_npc_nxt   = out_npc_r;
    out_done_nxt  = out_done_r;
    out_rv_nxt    = out_rv_r;
    out_st_nxt    = out_st_r;
    mem_en        = 1'b0;
    mem_we        = 1'b0;
    mem_addr      = dep_m2[ADDR_W-1:0];
    div_req.start    = 1'b0;
    div_req.dividend = mem_rdata;
    div_req.divisor  = tos_r;
    res_commit    = 1'b0;
    res_npc       = pc_r;
    res_done      = 1'b0;
    res_rv        = '0;
    res_st        = ST_OK;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mem_en    = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (mode_r == OP_DIV && depth_r >= DEP_W'(2) && tos_r != '0) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIV;
        end else if (out_free) begin
          res_commit = 1'b1;
          state_nxt  = S_IDLE;
          unique case (mode_r) inside
            OP_RET: begin
              if (depth_r == '0) begin
                res_st = ST_UNDER;
              end else begin
                res_done  = 1'b1;
                res_rv    = tos_r;
                res_st    = (depth_r != DEP_W'(1)) ? ST_NOTSINGLE : ST_OK;
                depth_nxt = '0;
                res_npc   = '0;
              end
            end
            OP_PUSH: begin
              if (full) begin
                res_st = ST_OVER;
              end else begin
                if (depth_r != '0) begin
                  mem_en   = 1'b1;
                  mem_we   = 1'b1;
                  mem_addr = dep_m1[ADDR_W-1:0];
                end
                tos_nxt   = opnd_r;
                depth_nxt = depth_r + DEP_W'(1);
                res_npc   = pc_inc2;
              end
            end
            OP_CALL, OP_DEBUG: begin
              res_npc = pc_inc1;
            end
            OP_ADD, OP_SUB, OP_MUL, OP_CMP, OP_DIV: begin
              if (depth_r < DEP_W'(2)) begin
                res_st = ST_UNDER;
              end else if (mode_r == OP_DIV) begin
                res_st = ST_DIVZ;
              end else begin
                tos_nxt   = alu;
                depth_nxt = dep_m1;
                res_npc   = pc_inc1;
              end
            end
            OP_GOTO: begin
              res_npc = target;
            end
            OP_BRZ: begin
              if (depth_r == '0) begin
                res_st = ST_UNDER;
              end else begin
                tos_nxt   = mem_rdata;
                depth_nxt = dep_m1;
                res_npc   = (tos_r == '0) ? target : pc_inc2;
              end
            end
            OP_DUP: begin
              if (depth_r == '0) begin
                res_st = ST_UNDER;
              end else if (full) begin
                res_st = ST_OVER;
              end else begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = dep_m1[ADDR_W-1:0];
                depth_nxt = depth_r + DEP_W'(1);
                res_npc   = pc_inc1;
              end
            end
            default: begin
              res_st = ST_BADOP;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done && out_free) begin
          res_commit = 1'b1;
          tos_nxt    = div_rsp.quotient;
          depth_nxt  = dep_m1;
          res_npc    = pc_inc1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    npc_ext = 32'(res_npc);
    if (res_commit) begin
      pc_nxt        = res_npc;
      out_valid_nxt = 1'b1;
      out_npc_nxt   = npc_ext[SBE_NPC_W-1:0];
      out_done_nxt  = res_done;
      out_rv_nxt    = res_rv;
      out_st_nxt    = res_st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      depth_r     <= '0;
      pc_r        <= '0;
      limit_r     <= SBE_LIMIT_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      depth_r     <= depth_nxt;
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        limit_r <= cfg_wr_data;
      end
    end
    tos_r      <= tos_nxt;
    out_npc_r  <= out_npc_nxt;
    out_done_r <= out_done_nxt;
    out_rv_r   <= out_rv_nxt;
    out_st_r   <= out_st_nxt;
    if (in_valid && in_ready) begin
      mode_r <= in_mode;
      opnd_r <= in_operand;
    end
  end

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_next_pc      = out_npc_r;
  assign out_done_res     = out_done_r;
  assign out_return_value = out_rv_r;
  assign out_status       = out_st_r;

  `SBE_ASSERT(a_depth_step, (depth_r != $past(depth_r)) |-> (depth_r == $past(depth_r) + 1 || depth_r == $past(depth_r) - 1 || depth_r == '0), "stack depth jumped")
  `SBE_ASSERT(a_div_depth, (state_r == S_DIV) |-> (depth_r >= DEP_W'(2)), "divide with short stack")
  `SBE_ASSERT(a_err_pc, ($rose(out_valid_r) && out_st_r != ST_OK && out_st_r != ST_NOTSINGLE) |-> (pc_r == $past(pc_r)), "pc moved on error")
  `SBE_ASSERT_RST(a_reset, !rst_n |=> (state_r == S_IDLE && !out_valid_r && depth_r == '0), "bad reset state")

endmodule

[tb/tb_top.sv]
module tb_top import sbe_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] MODE_BAD_LO = 4'd12;
  localparam logic [3:0] MODE_BAD_HI = 4'd15;
  localparam int ITEMS_PER_PHASE = 120;
  localparam int LONG_HOLD = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NDIR = 30;
  localparam int NPHASE = 6;

  typedef struct packed {
    logic [SBE_NPC_W-1:0] npc;
    logic                 done;
    word_t                rv;
    status_t              st;
  } outcome_t;

  typedef struct {
    logic [3:0] mode;
    word_t      imm;
    int         lim;
    bit         typed;
    outcome_t   want;
  } drow_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_wr_en;
  logic [SBE_LIMIT_W-1:0] cfg_wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [3:0]             in_mode;
  logic signed [31:0]     in_operand;
  logic                   out_valid;
  logic                   out_ready;
  logic [SBE_NPC_W-1:0]   out_next_pc;
  logic                   out_done_res;
  logic signed [31:0]     out_return_value;
  logic [2:0]             out_status;

  stack_bytecode_executor dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_operand       (in_operand),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_next_pc      (out_next_pc),
    .out_done_res     (out_done_res),
    .out_return_value (out_return_value),
    .out_status       (out_status)
  );

  // machine state as seen by the checker
  word_t                  mdl_stack [SBE_STACK_DEPTH];
  int unsigned            mdl_depth;
  int unsigned            mdl_limit;
  logic [SBE_PC_BITS-1:0] mdl_pc;

  outcome_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int stuck_cycles = 0;
  int burst_left = 0;

  drow_t directed [NDIR] = '{
    '{OP_RET,        32'd0,        0, 1'b1, '{16'd0, 1'b0, 32'd0, ST_UNDER}},
    '{MODE_BAD_LO,   32'd0,        0, 1'b1, '{16'd0, 1'b0, 32'd0, ST_BADOP}},
    '{OP_PUSH,       32'h80000000, 0, 1'b1, '{16'd2, 1'b0, 32'd0, ST_OK}},
    '{OP_DIV,        32'd0,        0, 1'b1, '{16'd2, 1'b0, 32'd0, ST_UNDER}},
    '{OP_PUSH,       32'd0,        0, 1'b1, '{16'd4, 1'b0, 32'd0, ST_OK}},
    '{OP_DIV,        32'd0,        0, 1'b1, '{16'd4, 1'b0, 32'd0, ST_DIVZ}},
    '{OP_ADD,        32'd0,        0, 1'b0, '0},
    '{OP_PUSH,       SBE_NEG_ONE,  0, 1'b0, '0},
    '{OP_DIV,        32'd0,        0, 1'b0, '0},
    '{OP_PUSH,       32'h7FFFFFFF, 0, 1'b0, '0},
    '{OP_SUB,        32'd0,        0, 1'b0, '0},
    '{OP_DUP,        32'd0,        0, 1'b0, '0},
    '{OP_CMP,        32'd0,        0, 1'b0, '0},
    '{OP_BRZ,        32'h00012345, 0, 1'b0, '0},
    '{OP_PUSH,       32'd5,        0, 1'b0, '0},
    '{OP_BRZ,        32'd100,      0, 1'b0, '0},
    '{OP_GOTO,       SBE_NEG_ONE,  0, 1'b0, '0},
    '{OP_CALL,       32'd0,        0, 1'b0, '0},
    '{OP_DEBUG,      32'd0,        0, 1'b0, '0},
    '{OP_PUSH,       -32'sd7,      0, 1'b0, '0},
    '{OP_PUSH,       32'd2,        0, 1'b0, '0},
    '{OP_DIV,        32'd0,        0, 1'b0, '0},
    '{OP_DUP,        32'd0,        0, 1'b0, '0},
    '{OP_MUL,        32'd0,        0, 1'b0, '0},
    '{OP_DUP,        32'd0,        0, 1'b0, '0},
    '{OP_RET,        32'd0,        0, 1'b1, '{16'd0, 1'b1, 32'd9, ST_NOTSINGLE}},
    '{OP_PUSH,       32'd42,       1, 1'b1, '{16'd2, 1'b0, 32'd0, ST_OK}},
    '{OP_PUSH,       32'd9,        0, 1'b1, '{16'd2, 1'b0, 32'd0, ST_OVER}},
    '{OP_DUP,        32'd0,        0, 1'b1, '{16'd2, 1'b0, 32'd0, ST_OVER}},
    '{OP_RET,        32'd0,        0, 1'b1, '{16'd0, 1'b1, 32'd42, ST_OK}}
  };

  int phase_limit [NPHASE] = '{1, 64, 2, 17, 64, 3};
  int phase_push  [NPHASE] = '{30, 75, 40, 55, 35, 45};

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic outcome_t execute_insn(logic [3:0] m, word_t imm);
    outcome_t    r;
    word_t       a, b, ma, mb, q;
    int unsigned room;
    room = (mdl_limit < SBE_STACK_DEPTH) ? mdl_limit : SBE_STACK_DEPTH;
    r = '0;
    r.npc = mdl_pc;
    r.st = ST_OK;
    case (m)
      OP_RET: begin
        if (mdl_depth == 0) r.st = ST_UNDER;
        else begin
          r.done = 1'b1;
          r.rv = mdl_stack[mdl_depth-1];
          r.st = (mdl_depth != 1) ? ST_NOTSINGLE : ST_OK;
          mdl_depth = 0;
          r.npc = '0;
        end
      end
      OP_PUSH: begin
        if (mdl_depth >= room) r.st = ST_OVER;
        else begin
          mdl_stack[mdl_depth] = imm;
          mdl_depth++;
          r.npc = mdl_pc + 2'd2;
        end
      end
      OP_CALL, OP_DEBUG: r.npc = mdl_pc + 1'b1;
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_CMP: begin
        if (mdl_depth < 2) r.st = ST_UNDER;
        else begin
          a = mdl_stack[mdl_depth-2];
          b = mdl_stack[mdl_depth-1];
          if (m == OP_DIV && b == word_t'(0)) r.st = ST_DIVZ;
          else begin
            case (m)
              OP_ADD: a = a + b;
              OP_SUB: a = a - b;
              OP_MUL: a = a * b;
              OP_DIV: begin
                // magnitude divide, so min / -1 wraps to min
                ma = a[31] ? ~a + 1'b1 : a;
                mb = b[31] ? ~b + 1'b1 : b;
                q = ma / mb;
                a = (a[31] != b[31]) ? ~q + 1'b1 : q;
              end
              default: begin
                if ($signed(a) < $signed(b)) a = SBE_NEG_ONE;
                else if ($signed(a) > $signed(b)) a = word_t'(1);
                else a = word_t'(0);
              end
            endcase
            mdl_stack[mdl_depth-2] = a;
            mdl_depth--;
            r.npc = mdl_pc + 1'b1;
          end
        end
      end
      OP_GOTO: r.npc = imm[SBE_PC_BITS-1:0];
      OP_BRZ: begin
        if (mdl_depth == 0) r.st = ST_UNDER;
        else begin
          mdl_depth--;
          r.npc = (mdl_stack[mdl_depth] == word_t'(0)) ? imm[SBE_PC_BITS-1:0]
                                                       : mdl_pc + 2'd2;
        end
      end
      OP_DUP: begin
        if (mdl_depth == 0) r.st = ST_UNDER;
        else if (mdl_depth >= room) r.st = ST_OVER;
        else begin
          mdl_stack[mdl_depth] = mdl_stack[mdl_depth-1];
          mdl_depth++;
          r.npc = mdl_pc + 1'b1;
        end
      end
      default: r.st = ST_BADOP;
    endcase
    mdl_pc = r.npc;
    return r;
  endfunction

  function automatic word_t pick_imm();
    word_t v;
    case ($urandom_range(0, 9))
      0: v = word_t'(0);
      1, 2: v = word_t'($urandom_range(0, 6)) - 3;
      3: v = 32'h80000000;
      4: v = 32'h7FFFFFFF;
      5: v = SBE_NEG_ONE;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly programs that keep the stack legal, plus stray and bad opcodes
  function automatic void pick_insn(int push_pct, output logic [3:0] m, output word_t imm);
    int unsigned r, room;
    room = (mdl_limit < SBE_STACK_DEPTH) ? mdl_limit : SBE_STACK_DEPTH;
    r = $urandom_range(0, 99);
    if (r < 3) m = 4'($urandom_range(MODE_BAD_LO, MODE_BAD_HI));
    else if (r < 8) m = 4'($urandom_range(0, 15));
    else if (r < 10) m = OP_RET;
    else if (mdl_depth == 0) m = OP_PUSH;
    else if (mdl_depth < room && $urandom_range(0, 99) < push_pct)
      m = ($urandom_range(0, 3) == 0) ? OP_DUP : OP_PUSH;
    else begin
      case ($urandom_range(0, 10))
        0: m = OP_ADD;
        1: m = OP_SUB;
        2: m = OP_MUL;
        3: m = OP_DIV;
        4: m = OP_CMP;
        5: m = OP_BRZ;
        6: m = OP_GOTO;
        7: m = OP_CALL;
        8: m = OP_DEBUG;
        9: m = OP_DUP;
        default: m = OP_PUSH;
      endcase
    end
    imm = pick_imm();
  endfunction

  task automatic send_insn(logic [3:0] m, word_t imm, bit typed, outcome_t want);
    outcome_t got;
    in_valid <= 1'b1;
    in_mode <= m;
    in_operand <= imm;
    do @(posedge clk); while (!in_ready);
    got = execute_insn(m, imm);
    pending_results.push_back(typed ? want : got);
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic set_limit(int v);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= SBE_LIMIT_W'(v);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    mdl_limit = v;
  endtask

  initial begin : stimulus
    outcome_t   none;
    logic [3:0] m;
    word_t      imm;
    none = '0;
    mdl_depth = 0;
    mdl_pc = '0;
    mdl_limit = SBE_LIMIT_RST;
    in_valid <= 1'b0;
    in_mode <= '0;
    in_operand <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) begin
      if (directed[i].lim != 0) set_limit(directed[i].lim);
      send_insn(directed[i].mode, directed[i].imm, directed[i].typed, directed[i].want);
      pace_sender();
    end
    foreach (phase_limit[p]) begin
      set_limit(phase_limit[p]);
      repeat (ITEMS_PER_PHASE) begin
        pick_insn(phase_push[p], m, imm);
        send_insn(m, imm, 1'b0, none);
        pace_sender();
      end
    end
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("tb_top: PASS");
    else $display("tb_top: FAIL");
    $finish;
  end

  // receiver: random ready styles, one long hold-off midway to back up the input
  initial begin : receiver
    int style, run;
    bit long_hold_done;
    long_hold_done = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && results_seen >= 400) begin
        long_hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      run = $urandom_range(4, 48);
      repeat (run) begin
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) != 0);
          default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result transfer with nothing expected, next_pc %0h",
                   $time, out_next_pc);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (out_next_pc !== want.npc || out_done_res !== want.done ||
            out_return_value !== want.rv || out_status !== want.st) begin
          if (mismatches < 10)
            $display("%0t: mismatch exp/got next_pc %0h/%0h done %0b/%0b ret %0h/%0h st %0d/%0d",
                     $time, want.npc, out_next_pc, want.done, out_done_res, want.rv,
                     out_return_value, want.st, out_status);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
